FILE: src/bea_pkg.sv
// Shared types and constants of the bitmap extent allocator.
package bea_pkg;

    localparam int WORD_BITS = 16;

    typedef struct packed {
        logic       kind;
        logic [4:0] block_count;
        logic [8:0] index_block;
    } t_in;

    typedef struct packed {
        logic       ok;
        logic [8:0] assigned_index;
        logic [8:0] extent_start;
        logic [4:0] extent_length;
        logic       last;
    } t_out;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_REJ_ALLOC,
        OP_REJ_FREE
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [4:0] count;
        logic [8:0] idx;
    } t_cmd;

    typedef struct packed {
        logic queue_full;
        logic clearing;
    } t_fe_stat;

endpackage

FILE: src/bea_front.sv
// Front end: accepts words and classifies them into queue commands.
module bea_front #(
    parameter int NUM_BLOCKS      = 512,
    parameter int MAX_FILE_BLOCKS = 16
) (
    input  logic              i_in_valid,
    input  bea_pkg::t_in      i_in_data,
    input  bea_pkg::t_fe_stat i_stat,
    output logic              o_in_stall,
    output logic              o_push,
    output bea_pkg::t_cmd     o_cmd
);

    always_comb begin
        o_in_stall = i_stat.queue_full || i_stat.clearing;
        o_push     = i_in_valid && !o_in_stall;
        o_cmd.count = i_in_data.block_count;
        if (i_in_data.kind == bea_pkg::KIND_ALLOC) begin
            o_cmd.idx = '0;
            if (i_in_data.block_count == 5'd0 || int'(i_in_data.block_count) > MAX_FILE_BLOCKS)
            begin
                o_cmd.op = bea_pkg::OP_REJ_ALLOC;
            end else begin
                o_cmd.op = bea_pkg::OP_ALLOC;
            end
        end else begin
            o_cmd.idx = i_in_data.index_block;
            if (int'(i_in_data.index_block) >= NUM_BLOCKS) begin
                o_cmd.op = bea_pkg::OP_REJ_FREE;
            end else begin
                o_cmd.op = bea_pkg::OP_FREE;
            end
        end
    end

endmodule

FILE: src/bea_queue.sv
// Two-entry command queue between front and back.
module bea_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bea_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_vld,
    output bea_pkg::t_cmd o_cmd
);

    bea_pkg::t_cmd r_slot [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic [1:0]    n_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_vld   = (r_cnt != 2'd0);
    assign o_cmd   = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_vld;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

endmodule

FILE: src/bea_back.sv
// Back end: bitmap scan, extent recording, freeing and the output register.
module bea_back #(
    parameter int NUM_BLOCKS      = 512,
    parameter int MAX_FILE_BLOCKS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_vld,
    input  bea_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_clearing,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output bea_pkg::t_out o_out_data
);

    localparam int WB    = bea_pkg::WORD_BITS;
    localparam int NW    = (NUM_BLOCKS + WB - 1) / WB;
    localparam int WAW   = (NW > 1) ? $clog2(NW) : 1;
    localparam int BAW   = WAW + 4;
    localparam int FW    = (MAX_FILE_BLOCKS > 1) ? $clog2(MAX_FILE_BLOCKS) : 1;
    localparam int LW    = $clog2(MAX_FILE_BLOCKS + 1);
    localparam int SW    = (LW > 5) ? LW : 5;
    localparam int CW    = $clog2(NUM_BLOCKS + 1) + 1;
    localparam int LASTB = NUM_BLOCKS - (NW - 1) * WB;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_FAIL,
        S_A_RD, S_A_CNT, S_T_RD, S_T_LD, S_T_RUN, S_T_END, S_I_RD, S_I_WR,
        S_F_RD, S_F_CHK, S_F_CNT, S_F_ERD, S_F_ELD, S_F_WRD, S_F_CLR,
        S_F_IDX, S_F_IWR, S_F_DONE
    } t_state;

    function automatic logic [4:0] first_set(input logic [WB-1:0] v);
        logic [4:0] r;
        r = 5'd16;
        for (int i = WB - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [WB-1:0] span_mask(input logic [4:0] lo, input logic [4:0] hi);
        logic [WB-1:0] m;
        for (int i = 0; i < WB; i++) begin
            m[i] = (5'(i) >= lo) && (5'(i) < hi);
        end
        return m;
    endfunction

    function automatic logic [4:0] pop_count(input logic [WB-1:0] v);
        logic [4:0] c;
        c = '0;
        for (int i = 0; i < WB; i++) begin
            c = c + {4'd0, v[i]};
        end
        return c;
    endfunction

    // memories
    logic [WB-1:0]     fm_mem  [NW];
    logic [WB-1:0]     im_mem  [NW];
    logic [BAW+LW-1:0] ext_mem [2**(BAW+FW)];
    logic [LW-1:0]     cnt_mem [2**BAW];

    logic [WB-1:0]     r_fm_q, r_im_q;
    logic [BAW+LW-1:0] r_ext_q;
    logic [LW-1:0]     r_cnt_q;

    logic              fm_re, fm_we, im_re, im_we, ext_re, ext_we, cnt_re, cnt_we;
    logic [WAW-1:0]    fm_raddr, fm_waddr, im_addr;
    logic [WB-1:0]     fm_wdata, im_wdata;
    logic [BAW+FW-1:0] ext_addr;
    logic [BAW+LW-1:0] ext_wdata;
    logic [LW-1:0]     cnt_wdata;

    // control registers
    t_state         r_state, n_state;
    bea_pkg::t_op   r_op, n_op;
    logic [4:0]     r_n, n_n;
    logic [8:0]     r_in_idx, n_in_idx;
    logic [BAW-1:0] r_idx, n_idx;
    logic [WAW-1:0] r_addr, n_addr;
    logic [CW-1:0]  r_found, n_found;
    logic           r_have, n_have;
    logic           r_first, n_first;
    logic [WB-1:0]  r_word, n_word;
    logic [4:0]     r_p, n_p;
    logic [LW-1:0]  r_rem, n_rem;
    logic           r_open, n_open;
    logic [BAW-1:0] r_rstart, n_rstart;
    logic [LW-1:0]  r_rlen, n_rlen;
    logic [LW-1:0]  r_runs, n_runs;
    logic [LW-1:0]  r_rtot, n_rtot;
    logic           r_out_vld;
    bea_pkg::t_out  r_out, n_out;
    logic           emit, can_emit;

    logic [WB-1:0]  fbits, ubits, fr, clr_mask;
    logic [4:0]     s_pos, e_pos, avail, k5, fpos, pc, lo5, room, span5;
    logic [SW-1:0]  avail_w, rem_w, k_w, room_w, span_w;
    logic [CW-1:0]  nf;
    logic [BAW-1:0] idx_c;
    logic [3:0]     ibit;
    logic [WAW-1:0] iword;
    logic [BAW+8:0] idx_x, start_x;
    logic [LW+4:0]  len_x;

    always_ff @(posedge i_clk) begin
        if (fm_we) begin
            fm_mem[fm_waddr] <= fm_wdata;
        end
        if (fm_re) begin
            r_fm_q <= fm_mem[fm_raddr];
        end
        if (im_we) begin
            im_mem[im_addr] <= im_wdata;
        end
        if (im_re) begin
            r_im_q <= im_mem[im_addr];
        end
        if (ext_we) begin
            ext_mem[ext_addr] <= ext_wdata;
        end
        if (ext_re) begin
            r_ext_q <= ext_mem[ext_addr];
        end
        if (cnt_we) begin
            cnt_mem[r_idx] <= cnt_wdata;
        end
        if (cnt_re) begin
            r_cnt_q <= cnt_mem[r_idx];
        end
    end

    assign can_emit    = !r_out_vld || !i_out_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign o_clearing  = (r_state == S_CLR);

    always_comb begin
        ibit    = r_idx[3:0];
        iword   = r_idx[BAW-1:4];
        idx_x   = {9'd0, r_idx};
        start_x = {9'd0, r_rstart};
        len_x   = {5'd0, r_rlen};

        fbits   = ~r_word & span_mask(r_p, 5'd16);
        s_pos   = first_set(fbits);
        ubits   = r_word & span_mask(s_pos, 5'd16);
        e_pos   = first_set(ubits);
        avail   = e_pos - s_pos;
        avail_w = SW'(avail);
        rem_w   = SW'(r_rem);
        k_w     = (avail_w < rem_w) ? avail_w : rem_w;
        k5      = k_w[4:0];

        fr      = ~r_fm_q;
        fpos    = first_set(fr);
        pc      = pop_count(fr);
        nf      = r_found + CW'(pc);
        idx_c   = r_have ? r_idx : {r_addr, fpos[3:0]};

        lo5      = {1'b0, r_rstart[3:0]};
        room     = 5'd16 - lo5;
        room_w   = SW'(room);
        span_w   = (room_w < rem_w) ? room_w : rem_w;
        span5    = span_w[4:0];
        clr_mask = span_mask(lo5, lo5 + span5);

        n_state  = r_state;
        n_op     = r_op;
        n_n      = r_n;
        n_in_idx = r_in_idx;
        n_idx    = r_idx;
        n_addr   = r_addr;
        n_found  = r_found;
        n_have   = r_have;
        n_first  = r_first;
        n_word   = r_word;
        n_p      = r_p;
        n_rem    = r_rem;
        n_open   = r_open;
        n_rstart = r_rstart;
        n_rlen   = r_rlen;
        n_runs   = r_runs;
        n_rtot   = r_rtot;

        o_pop     = 1'b0;
        fm_re     = 1'b0;
        fm_we     = 1'b0;
        fm_raddr  = r_addr;
        fm_waddr  = r_addr;
        fm_wdata  = r_word;
        im_re     = 1'b0;
        im_we     = 1'b0;
        im_addr   = iword;
        im_wdata  = r_im_q | (WB'(1) << ibit);
        ext_re    = 1'b0;
        ext_we    = 1'b0;
        ext_addr  = {r_idx, r_runs[FW-1:0]};
        ext_wdata = {r_rstart, r_rlen};
        cnt_re    = 1'b0;
        cnt_we    = 1'b0;
        cnt_wdata = r_runs + LW'(1);

        emit  = 1'b0;
        n_out = '{ok: 1'b1, assigned_index: idx_x[8:0], extent_start: start_x[8:0],
                  extent_length: len_x[4:0], last: 1'b0};

        unique case (r_state)
            S_CLR: begin
                fm_we    = 1'b1;
                fm_wdata = (r_addr == WAW'(NW - 1)) ? ~span_mask(5'd0, 5'(LASTB)) : '0;
                im_we    = 1'b1;
                im_addr  = r_addr;
                im_wdata = '0;
                if (r_addr == WAW'(NW - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + WAW'(1);
                end
            end
            S_IDLE: begin
                if (i_cmd_vld) begin
                    o_pop    = 1'b1;
                    n_op     = i_cmd.op;
                    n_n      = i_cmd.count;
                    n_in_idx = i_cmd.idx;
                    n_idx    = BAW'(i_cmd.idx);
                    n_addr   = '0;
                    n_found  = '0;
                    n_have   = 1'b0;
                    unique case (i_cmd.op)
                        bea_pkg::OP_ALLOC: n_state = S_A_RD;
                        bea_pkg::OP_FREE:  n_state = S_F_RD;
                        default:           n_state = S_FAIL;
                    endcase
                end
            end
            S_FAIL: begin
                n_out = '{ok: 1'b0, assigned_index: r_in_idx, extent_start: '0,
                          extent_length: '0, last: 1'b1};
                if (can_emit) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_A_RD: begin
                fm_re   = 1'b1;
                n_state = S_A_CNT;
            end
            S_A_CNT: begin
                n_found = nf;
                n_idx   = idx_c;
                n_have  = r_have || (fr != '0);
                if (nf >= CW'(r_n) + CW'(1)) begin
                    n_addr  = idx_c[BAW-1:4];
                    n_first = 1'b1;
                    n_rem   = LW'(r_n);
                    n_open  = 1'b0;
                    n_runs  = '0;
                    n_state = S_T_RD;
                end else if (r_addr == WAW'(NW - 1)) begin
                    n_state = S_FAIL;
                end else begin
                    n_addr  = r_addr + WAW'(1);
                    n_state = S_A_RD;
                end
            end
            S_T_RD: begin
                fm_re   = 1'b1;
                n_state = S_T_LD;
            end
            S_T_LD: begin
                n_first = 1'b0;
                if (r_first) begin
                    n_word = r_fm_q | (WB'(1) << ibit);
                    n_p    = {1'b0, ibit} + 5'd1;
                end else begin
                    n_word = r_fm_q;
                    n_p    = '0;
                end
                n_state = S_T_RUN;
            end
            S_T_RUN: begin
                if (r_open && s_pos != r_p) begin
                    // run broken by a used block: close it
                    if (can_emit) begin
                        ext_we = 1'b1;
                        emit   = 1'b1;
                        n_runs = r_runs + LW'(1);
                        n_open = 1'b0;
                    end
                end else if (fbits == '0) begin
                    fm_we   = 1'b1;
                    n_addr  = r_addr + WAW'(1);
                    n_state = S_T_RD;
                end else begin
                    n_word = r_word | span_mask(s_pos, s_pos + k5);
                    n_p    = s_pos + k5;
                    n_rem  = r_rem - LW'(k5);
                    n_open = 1'b1;
                    if (r_open) begin
                        n_rlen = r_rlen + LW'(k5);
                    end else begin
                        n_rstart = {r_addr, s_pos[3:0]};
                        n_rlen   = LW'(k5);
                    end
                    if (r_rem == LW'(k5)) begin
                        n_state = S_T_END;
                    end
                end
            end
            S_T_END: begin
                n_out.last = 1'b1;
                if (can_emit) begin
                    emit    = 1'b1;
                    ext_we  = 1'b1;
                    fm_we   = 1'b1;
                    cnt_we  = 1'b1;
                    n_open  = 1'b0;
                    n_state = S_I_RD;
                end
            end
            S_I_RD: begin
                im_re   = 1'b1;
                n_state = S_I_WR;
            end
            S_I_WR: begin
                im_we   = 1'b1;
                n_state = S_IDLE;
            end
            S_F_RD: begin
                im_re   = 1'b1;
                n_state = S_F_CHK;
            end
            S_F_CHK: begin
                if (!r_im_q[ibit]) begin
                    n_state = S_FAIL;
                end else begin
                    cnt_re  = 1'b1;
                    n_state = S_F_CNT;
                end
            end
            S_F_CNT: begin
                n_rtot  = r_cnt_q;
                n_runs  = '0;
                n_state = S_F_ERD;
            end
            S_F_ERD: begin
                if (r_runs == r_rtot) begin
                    n_state = S_F_IDX;
                end else begin
                    ext_re  = 1'b1;
                    n_state = S_F_ELD;
                end
            end
            S_F_ELD: begin
                n_rstart = r_ext_q[BAW+LW-1:LW];
                n_rem    = r_ext_q[LW-1:0];
                n_runs   = r_runs + LW'(1);
                n_state  = S_F_WRD;
            end
            S_F_WRD: begin
                fm_re    = 1'b1;
                fm_raddr = r_rstart[BAW-1:4];
                n_state  = S_F_CLR;
            end
            S_F_CLR: begin
                fm_we    = 1'b1;
                fm_waddr = r_rstart[BAW-1:4];
                fm_wdata = r_fm_q & ~clr_mask;
                n_rem    = r_rem - LW'(span5);
                n_rstart = r_rstart + BAW'(span5);
                n_state  = (r_rem == LW'(span5)) ? S_F_ERD : S_F_WRD;
            end
            S_F_IDX: begin
                fm_re    = 1'b1;
                fm_raddr = iword;
                im_re    = 1'b1;
                n_state  = S_F_IWR;
            end
            S_F_IWR: begin
                fm_we    = 1'b1;
                fm_waddr = iword;
                fm_wdata = r_fm_q & ~(WB'(1) << ibit);
                im_we    = 1'b1;
                im_wdata = r_im_q & ~(WB'(1) << ibit);
                n_state  = S_F_DONE;
            end
            S_F_DONE: begin
                n_out = '{ok: 1'b1, assigned_index: r_in_idx, extent_start: '0,
                          extent_length: '0, last: 1'b1};
                if (can_emit) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_n      <= n_n;
        r_in_idx <= n_in_idx;
        r_idx    <= n_idx;
        r_found  <= n_found;
        r_have   <= n_have;
        r_first  <= n_first;
        r_word   <= n_word;
        r_p      <= n_p;
        r_rem    <= n_rem;
        r_open   <= n_open;
        r_rstart <= n_rstart;
        r_rlen   <= n_rlen;
        r_runs   <= n_runs;
        r_rtot   <= n_rtot;
        if (emit) begin
            r_out <= n_out;
        end
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_addr    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

endmodule

FILE: src/bitmap_extent_allocator_top.sv
// Top level of the bitmap extent allocator.
//
//  port group   direction  word       handshake
//  in           input      t_in       i_in_valid / o_in_stall
//  out          output     t_out      o_out_valid / i_out_stall
//
// Allocate: the command is taken, 16-block bitmap words are scanned until n+1 free
// blocks are counted, then each word taken from is read, marked run by run and
// written back, each run is recorded and the index block is marked. A failed allocate
// ends after the scan. Free: the index block is checked, the bitmap words of each run
// are cleared and the index block is cleared. After reset a clearing pass stalls input.
// Each result waits in the output register while the output stalls.
module bitmap_extent_allocator_top #(
    parameter int NUM_BLOCKS      = 512,
    parameter int MAX_FILE_BLOCKS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  bea_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output bea_pkg::t_out o_out_data
);

    bea_pkg::t_fe_stat stat;
    bea_pkg::t_cmd     push_cmd;
    bea_pkg::t_cmd     q_cmd;
    logic              push;
    logic              pop;
    logic              q_vld;

    bea_front #(
        .NUM_BLOCKS      (NUM_BLOCKS),
        .MAX_FILE_BLOCKS (MAX_FILE_BLOCKS)
    ) u_front (
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    bea_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (stat.queue_full),
        .o_vld   (q_vld),
        .o_cmd   (q_cmd)
    );

    bea_back #(
        .NUM_BLOCKS      (NUM_BLOCKS),
        .MAX_FILE_BLOCKS (MAX_FILE_BLOCKS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_vld   (q_vld),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .o_clearing  (stat.clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
